@@ sv/gbe_pkg.sv @@
// shared types, constants and kernel table for the 5x5 blur
`timescale 1ns / 1ps
package gbe_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RING_ROWS = 8;
    localparam int RING_W = $clog2(RING_ROWS);
    localparam int ADDR_W = RING_W + COL_W;
    localparam int ROW_W = 13;
    localparam int WID_W = 11;
    localparam int HGT_W = 13;
    localparam int SUM_W = 16;
    localparam int WT_W = 8;
    localparam int PIX_W = 8;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0] blurred;
        logic             frame_end;
    } res_t;

    typedef struct packed {
        logic idle;
    } be_stat_t;

    function automatic logic [3:0] kern_weight(input logic [2:0] dy, input logic [2:0] dx);
        logic [1:0] r;
        logic [1:0] c;
        logic [3:0] k;
        r = (dy > 3'd2) ? 2'(3'd4 - dy) : dy[1:0];
        c = (dx > 3'd2) ? 2'(3'd4 - dx) : dx[1:0];
        case ({r, c})
            4'b0000: k = 4'd2;
            4'b0001: k = 4'd4;
            4'b0010: k = 4'd5;
            4'b0100: k = 4'd4;
            4'b0101: k = 4'd9;
            4'b0110: k = 4'd12;
            4'b1000: k = 4'd5;
            4'b1001: k = 4'd12;
            4'b1010: k = 4'd15;
            default: k = 4'd0;
        endcase
        return k;
    endfunction
endpackage

@@ sv/gbe_linebuf.sv @@
// ring of row buffers, one write and one registered read port
`timescale 1ns / 1ps
module gbe_linebuf
    import gbe_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data
);
    logic [PIX_W-1:0] mem [RING_ROWS*MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ sv/gbe_jobq.sv @@
// two-entry queue of output jobs between front and back
`timescale 1ns / 1ps
module gbe_jobq
    import gbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    input  logic rd_en,
    output job_t rd_data,
    output logic full,
    output logic empty
);
    job_t       q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rd_data = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            q_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en && !full) - 2'(rd_en && !empty);
        end
    end
endmodule

@@ sv/gbe_outq.sv @@
// two-entry result queue driving the output side
`timescale 1ns / 1ps
module gbe_outq
    import gbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t wr_data,
    input  logic rd_en,
    output res_t rd_data,
    output logic full,
    output logic empty
);
    res_t       q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rd_data = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            q_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en && !full) - 2'(rd_en && !empty);
        end
    end
endmodule

@@ sv/gbe_front.sv @@
// front end: accepts requests, stores pixels, issues output jobs
`timescale 1ns / 1ps
module gbe_front
    import gbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              kind,
    input  logic [PIX_W-1:0]  pixel,
    output logic              full,
    input  logic [WID_W-1:0]  w_eff,
    input  logic [HGT_W-1:0]  h_eff,
    input  logic              jq_full,
    input  logic              jq_empty,
    input  be_stat_t          be_stat,
    output logic              mem_wr_en,
    output logic [ADDR_W-1:0] mem_wr_addr,
    output logic [PIX_W-1:0]  mem_wr_data,
    output logic              job_push,
    output job_t              job
);
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             done_reg, done_next;
    logic             hold_reg, hold_next;
    logic             accept;
    logic             do_write;
    logic             ready;
    logic             last;
    logic [ROW_W:0]   ny;
    logic [COL_W+1:0] nx;
    logic [ROW_W:0]   orow2;
    logic [COL_W+1:0] ocol2;
    logic [COL_W:0]   icol1;
    logic [ROW_W:0]   irow1;
    logic [COL_W:0]   ocol1;
    logic [ROW_W:0]   orow1;

    assign full = jq_full || hold_reg;
    assign accept = push && !full;
    assign do_write = accept && !kind && !done_reg;
    assign mem_wr_en = do_write;
    assign mem_wr_addr = {in_row_reg[RING_W-1:0], in_col_reg};
    assign mem_wr_data = pixel;

    assign icol1 = {1'b0, in_col_reg} + 1'b1;
    assign irow1 = {1'b0, in_row_reg} + 1'b1;
    assign ocol1 = {1'b0, out_col_reg} + 1'b1;
    assign orow1 = {1'b0, out_row_reg} + 1'b1;
    assign orow2 = {1'b0, out_row_reg} + 2'd2;
    assign ocol2 = {2'b0, out_col_reg} + 2'd2;

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        done_next = done_reg;
        if (do_write)
        begin
            if (icol1 >= w_eff)
            begin
                in_col_next = '0;
                if (irow1 >= {1'b0, h_eff})
                begin
                    in_row_next = '0;
                    done_next = 1'b1;
                end
                else
                begin
                    in_row_next = irow1[ROW_W-1:0];
                end
            end
            else
            begin
                in_col_next = icol1[COL_W-1:0];
            end
        end
        ny = (orow2 < {1'b0, h_eff}) ? orow2 : ({1'b0, h_eff} - 1'b1);
        nx = (ocol2 < {1'b0, w_eff}) ? ocol2 : ({1'b0, w_eff} - 1'b1);
        ready = done_next || ({1'b0, in_row_next} > ny)
            || (({1'b0, in_row_next} == ny) && ({2'b0, in_col_next} > nx));
        last = (ocol1 >= w_eff) && (orow1 >= {1'b0, h_eff});
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        hold_next = hold_reg;
        if (hold_reg && jq_empty && be_stat.idle)
        begin
            hold_next = 1'b0;
        end
        if (accept && ready)
        begin
            if (ocol1 >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = last ? '0 : orow1[ROW_W-1:0];
            end
            else
            begin
                out_col_next = ocol1[COL_W-1:0];
            end
            if (last)
            begin
                in_col_next = '0;
                in_row_next = '0;
                done_next = 1'b0;
                hold_next = 1'b1;
            end
        end
    end

    assign job_push = accept && ready;
    assign job.row = out_row_reg;
    assign job.col = out_col_reg;
    assign job.last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            done_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            done_reg <= done_next;
            hold_reg <= hold_next;
        end
    end
endmodule

@@ sv/gbe_back.sv @@
// back end: walks the 25 taps, accumulates, divides by in-frame weight
`timescale 1ns / 1ps
module gbe_back
    import gbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              jq_empty,
    input  job_t              jq_data,
    output logic              jq_pop,
    input  logic [WID_W-1:0]  w_eff,
    input  logic [HGT_W-1:0]  h_eff,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [PIX_W-1:0]  rd_data,
    input  logic              outq_full,
    output logic              res_push,
    output res_t              res,
    output be_stat_t          stat
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TAP  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]       state_reg, state_next;
    job_t             job_reg;
    logic [2:0]       dy_reg, dx_reg;
    logic             vld_d_reg;
    logic [3:0]       k_d_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [WT_W-1:0]  wt_reg;
    logic [WT_W-1:0]  rem_reg;
    logic [4:0]       cnt_reg;
    logic [ROW_W:0]   yf;
    logic [COL_W+1:0] xf;
    logic [ROW_W:0]   y;
    logic [COL_W+1:0] x;
    logic             in_frame;
    logic [WT_W:0]    rem_sh;
    logic             ge;

    assign yf = {1'b0, job_reg.row} + {{(ROW_W-2){1'b0}}, dy_reg};
    assign xf = {2'b0, job_reg.col} + {{(COL_W-1){1'b0}}, dx_reg};
    assign y = yf - 2'd2;
    assign x = xf - 2'd2;
    assign in_frame = (yf >= 2) && (y < {1'b0, h_eff}) && (xf >= 2) && (x < {1'b0, w_eff});
    assign rd_addr = {y[RING_W-1:0], x[COL_W-1:0]};
    assign rem_sh = {rem_reg, sum_reg[SUM_W-1]};
    assign ge = (rem_sh >= {1'b0, wt_reg});

    assign jq_pop = (state_reg == ST_IDLE) && !jq_empty;
    assign res_push = (state_reg == ST_PUSH) && !outq_full;
    assign res.blurred = (wt_reg == '0) ? '0 : sum_reg[PIX_W-1:0];
    assign res.frame_end = job_reg.last;
    assign stat.idle = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!jq_empty) state_next = ST_TAP;
            ST_TAP:  if (dy_reg == 3'd4 && dx_reg == 3'd4) state_next = ST_ACC;
            ST_ACC:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 5'd15) state_next = ST_PUSH;
            ST_PUSH: if (!outq_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg <= jq_data;
                dy_reg <= '0;
                dx_reg <= '0;
                sum_reg <= '0;
                wt_reg <= '0;
                vld_d_reg <= 1'b0;
            end
            ST_TAP, ST_ACC:
            begin
                if (dx_reg == 3'd4)
                begin
                    dx_reg <= '0;
                    dy_reg <= dy_reg + 1'b1;
                end
                else
                begin
                    dx_reg <= dx_reg + 1'b1;
                end
                vld_d_reg <= in_frame && (state_reg == ST_TAP);
                k_d_reg <= kern_weight(dy_reg, dx_reg);
                if (in_frame && state_reg == ST_TAP)
                begin
                    wt_reg <= wt_reg + {4'b0, kern_weight(dy_reg, dx_reg)};
                end
                if (vld_d_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(rd_data) * SUM_W'(k_d_reg);
                end
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? WT_W'(rem_sh - {1'b0, wt_reg}) : rem_sh[WT_W-1:0];
                sum_reg <= {sum_reg[SUM_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

@@ sv/gaussian_blur_5x5_edge_renorm.sv @@
// top level: config registers, front end, job queue, back end, result queue
// the back end works on one output at a time: it walks the 25 taps over the line memory read port,
// runs the 16-step divider and pushes its result before it takes the next job
// requests are taken each cycle while the job queue has room
// and held off after the last output of a frame until the back end has drained
// reset: asynchronous active low; counters and queues cleared, line memory not cleared
`timescale 1ns / 1ps
module gaussian_blur_5x5_edge_renorm
    import gbe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             push,
    output logic             full,
    input  logic             kind,
    input  logic [PIX_W-1:0] pixel,
    output logic             empty,
    input  logic             pop,
    output logic [PIX_W-1:0] blurred,
    output logic             frame_end
);
    logic [WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [PIX_W-1:0]  mem_wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_data;
    logic              job_push;
    job_t              job_in;
    job_t              job_out;
    logic              jq_pop;
    logic              jq_full;
    logic              jq_empty;
    be_stat_t          be_stat;
    logic              res_push;
    res_t              res_in;
    res_t              res_out;
    logic              outq_full;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {{(32-HGT_W){1'b0}}, height_reg} : {{(32-WID_W){1'b0}}, width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WID_W'(640);
            height_reg <= HGT_W'(480);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
            begin
                height_reg <= pwdata[HGT_W-1:0];
            end
            else
            begin
                width_reg <= pwdata[WID_W-1:0];
            end
        end
    end

    assign w_eff = (width_reg == '0) ? WID_W'(1)
        : (width_reg > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? HGT_W'(1) : height_reg;

    gbe_linebuf u_linebuf (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .kind        (kind),
        .pixel       (pixel),
        .full        (full),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .jq_full     (jq_full),
        .jq_empty    (jq_empty),
        .be_stat     (be_stat),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .job_push    (job_push),
        .job         (job_in)
    );

    gbe_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (jq_pop),
        .rd_data (job_out),
        .full    (jq_full),
        .empty   (jq_empty)
    );

    gbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .jq_empty  (jq_empty),
        .jq_data   (job_out),
        .jq_pop    (jq_pop),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .outq_full (outq_full),
        .res_push  (res_push),
        .res       (res_in),
        .stat      (be_stat)
    );

    gbe_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (outq_full),
        .empty   (empty)
    );

    assign blurred = res_out.blurred;
    assign frame_end = res_out.frame_end;
endmodule

@@ sim/gaussian_blur_5x5_edge_renorm_tb.sv @@
// self-checking testbench for the 5x5 edge-renormalized blur: predicted outputs vs. dut results
`timescale 1ns / 1ps
module gaussian_blur_5x5_edge_renorm_tb;
    import gbe_pkg::*;

    localparam bit KIND_PIXEL = 1'b0;
    localparam bit KIND_DRAIN = 1'b1;
    localparam int REG_WIDTH = 0;
    localparam int REG_HEIGHT = 1;
    localparam int LINES = 8;

    class blur_scoreboard;
        int kernel[5][5] = '{'{2, 4, 5, 4, 2}, '{4, 9, 12, 9, 4}, '{5, 12, 15, 12, 5},
                             '{4, 9, 12, 9, 4}, '{2, 4, 5, 4, 2}};
        bit [7:0] line_mem[LINES*MAX_WIDTH];
        bit [WID_W-1:0] width_reg = 11'd640;
        bit [HGT_W-1:0] height_reg = 13'd480;
        int in_row, in_col, out_row, out_col;
        bit complete;
        res_t blurred_q[$];
        int fails;

        function int eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int eff_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function bit ready(int w, int h);
            int ny, nx;
            if (complete) return 1;
            ny = (out_row + 2 < h) ? out_row + 2 : h - 1;
            nx = (out_col + 2 < w) ? out_col + 2 : w - 1;
            return in_row > ny || (in_row == ny && in_col > nx);
        endfunction

        function bit [7:0] blur_value(int w, int h);
            int sum, wt, y, x;
            sum = 0;
            wt = 0;
            for (int dy = -2; dy <= 2; dy++)
                for (int dx = -2; dx <= 2; dx++)
                begin
                    y = out_row + dy;
                    x = out_col + dx;
                    if (y >= 0 && x >= 0 && y < h && x < w)
                    begin
                        sum += line_mem[(y % LINES) * MAX_WIDTH + x] * kernel[dy+2][dx+2];
                        wt += kernel[dy+2][dx+2];
                    end
                end
            return (wt == 0) ? 8'd0 : 8'(sum / wt);
        endfunction

        function void note_request(bit k, bit [7:0] px);
            int w, h;
            res_t r;
            w = eff_w();
            h = eff_h();
            if (k == KIND_PIXEL && !complete)
            begin
                line_mem[(in_row % LINES) * MAX_WIDTH + in_col] = px;
                if (in_col + 1 >= w)
                begin
                    in_col = 0;
                    if (in_row + 1 >= h)
                    begin
                        in_row = 0;
                        complete = 1;
                    end
                    else
                        in_row++;
                end
                else
                    in_col++;
            end
            if (!ready(w, h)) return;
            r.blurred = blur_value(w, h);
            r.frame_end = 0;
            if (out_col + 1 >= w)
            begin
                out_col = 0;
                if (out_row + 1 >= h)
                begin
                    out_row = 0;
                    r.frame_end = 1;
                    in_row = 0;
                    in_col = 0;
                    complete = 0;
                end
                else
                    out_row++;
            end
            else
                out_col++;
            blurred_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_result(bit [7:0] b, bit fe);
            res_t r;
            if (blurred_q.size() == 0)
            begin
                report($sformatf("unexpected result blurred=%0d frame_end=%0d", b, fe));
                return;
            end
            r = blurred_q.pop_front();
            if (b !== r.blurred)
                report($sformatf("blurred %0d, predicted %0d", b, r.blurred));
            if (fe !== r.frame_end)
                report($sformatf("frame_end %0d, predicted %0d", fe, r.frame_end));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic push, full, kind, empty, pop, frame_end;
    logic [PIX_W-1:0] pixel, blurred;

    blur_scoreboard sb = new();
    int send_idle, recv_idle, n_sent;

    gaussian_blur_5x5_edge_renorm u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .kind(kind), .pixel(pixel),
        .empty(empty), .pop(pop), .blurred(blurred), .frame_end(frame_end)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(blurred, frame_end);
        pop <= ($urandom_range(99) >= recv_idle);
    end

    task send_request(bit k, bit [7:0] px);
        bit taken;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        kind <= k;
        pixel <= px;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        sb.note_request(k, px);
        n_sent++;
    endtask

    task reg_write(int idx, bit [31:0] val);
        bit [31:0] mask;
        mask = (idx == REG_WIDTH) ? 32'h7ff : 32'h1fff;
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 3'(4 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        pwrite <= 0;
        penable <= 0;
        @(posedge clk);
        penable <= 1;
        @(negedge clk);
        if ((prdata & mask) !== (val & mask))
            sb.report($sformatf("register %0d reads %0h", idx, prdata));
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        if (idx == REG_WIDTH)
            sb.width_reg = val[WID_W-1:0];
        else
            sb.height_reg = val[HGT_W-1:0];
    endtask

    task wait_idle();
        push <= 0;
        @(posedge clk);
        while (sb.blurred_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // extremes: 0/1 pattern of 0 and 255; noise: percent of stray drains
    task run_frame(int w, int h, bit extremes, int noise);
        int n;
        wait_idle();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        n = sb.eff_w() * sb.eff_h();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise)
                send_request(KIND_DRAIN, 8'($urandom));
            send_request(KIND_PIXEL, extremes ? ((i % 2) ? 8'hff : 8'h00) : 8'($urandom));
        end
        while (sb.complete)
            send_request(($urandom_range(99) < 80) ? KIND_DRAIN : KIND_PIXEL, 8'($urandom));
    endtask

    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        push = 0;
        kind = 0;
        pixel = 0;
        pop = 0;
        send_idle = 25;
        recv_idle = 59;
        n_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // drain with nothing ready, single pixel frames, pixel after complete
        send_request(KIND_DRAIN, 8'hff);
        run_frame(1, 1, 1, 0);
        run_frame(0, 0, 1, 0);
        run_frame(5, 4, 1, 0);
        while (n_sent < 500)
        begin
            if (n_sent > 250) begin send_idle = 59; recv_idle = 25; end
            run_frame(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24),
                      ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12), 0, 10);
        end
        send_idle = 0;
        recv_idle = 0;
        run_frame(2047, 1, 0, 2);
        run_frame(1, 150, 0, 1);
        wait_idle();
        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
sv/gbe_pkg.sv
sv/gbe_linebuf.sv
sv/gbe_jobq.sv
sv/gbe_outq.sv
sv/gbe_front.sv
sv/gbe_back.sv
sv/gaussian_blur_5x5_edge_renorm.sv
sim/gaussian_blur_5x5_edge_renorm_tb.sv
